// ===== hdl/lade_pkg.sv =====
// Shared types and constants for the linear attack/decay envelope.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lade_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_FRAC  = 16;
  localparam int GAIN_W     = GAIN_FRAC + 1;
  localparam int POS_W      = 26;
  localparam int ATK_W      = 25;
  localparam int HOLD_W     = 24;
  localparam int DEC_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int SUB_W      = POS_W + 1;
  localparam int STEP_W     = $clog2(GAIN_FRAC);
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

  localparam logic [POS_W-1:0]     POS_MAX  = {POS_W{1'b1}};
  localparam logic [GAIN_W-1:0]    UNITY    = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [STEP_W-1:0]    DIV_LAST = STEP_W'(GAIN_FRAC - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LEN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ATK,
    ST_HOLD,
    ST_DSUB,
    ST_DCMP,
    ST_DNUM,
    ST_DIV,
    ST_MUL
  } lade_state_t;

  typedef struct packed {
    logic [ATK_W-1:0]  attack_len;
    logic [HOLD_W-1:0] hold_end;
    logic [DEC_W-1:0]  decay_len;
  } lade_cfg_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain;
  } lade_scale_req_t;

endpackage

// ===== hdl/linear_attack_decay_envelope.sv =====
// Linear attack / hold / decay envelope applied to signed Q1.23 samples.
// Top level; depends on lade_pkg, lade_cfg_regs, lade_gain_seq, lade_scale.
//
// Usage: samples enter on in_* (tdata = sample_in) and leave on out_*
// (tdata = sample_out), one result per request. Each accepted sample
// advances a saturating 26-bit position counter; the position picks a
// gain: ramping up over attack_len samples, unity up to hold_end, ramping
// down over decay_len samples, then zero. Registers are written through
// cfg_* (index 0 attack_len, 1 hold_end, 2 decay_len); the user must do so
// only while no sample is in flight, which the block does not enforce.
// Sequence: an accepted request runs ATK and HOLD on the hold path; ATK,
// HOLD, DSUB and DCMP on the silent path; ATK and the divider in attack;
// ATK, HOLD, DSUB, DCMP, DNUM and the divider in decay. Each path ends in
// MUL, and the next request is taken only back in IDLE. The attack and
// decay paths use the 16 one-bit steps of the divider, which shares the
// sequencer's subtractor; the multiply and output registers follow.
// in_tready is high only while the sequencer is idle. A finished result
// waits in the output register while the next sample is processed; if the
// receiver stalls, the multiply stage fills and the sequencer holds.
// Reset (rst_n low, synchronous) clears the position to zero, empties the
// pipeline and sets attack_len = 1, hold_end = 0, decay_len = 1.
`timescale 1ns / 1ps

module linear_attack_decay_envelope (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lade_pkg::SAMPLE_W-1:0]   in_tdata,   // [23:0] sample_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lade_pkg::SAMPLE_W-1:0]   out_tdata,  // [23:0] sample_out
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lade_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lade_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lade_pkg::*;

  lade_cfg_t       cfg;
  lade_scale_req_t scale_req;
  logic            scale_ready;

  lade_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lade_gain_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_sample   ($signed(in_tdata)),
    .scale_req   (scale_req),
    .scale_ready (scale_ready)
  );

  lade_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .scale_req   (scale_req),
    .scale_ready (scale_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== hdl/lade_cfg_regs.sv =====
// Configuration register file: attack length, hold end and decay length.
// Depends on lade_pkg.
`timescale 1ns / 1ps

module lade_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lade_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lade_pkg::CFG_DATA_W-1:0] cfg_data,
  output lade_pkg::lade_cfg_t            cfg
);
  import lade_pkg::*;

  lade_cfg_t cfg_r;
  lade_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTACK_LEN: cfg_nxt.attack_len = cfg_data[ATK_W-1:0];
        CFG_HOLD_END:   cfg_nxt.hold_end   = cfg_data[HOLD_W-1:0];
        CFG_DECAY_LEN:  cfg_nxt.decay_len  = cfg_data[DEC_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_len <= ATK_W'(1);
      cfg_r.hold_end   <= '0;
      cfg_r.decay_len  <= DEC_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/lade_gain_seq.sv =====
// Gain sequencer: position counter, plus phase selection and a radix-2
// divider built around one shared subtractor. Depends on lade_pkg.
`timescale 1ns / 1ps

module lade_gain_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lade_pkg::lade_cfg_t                 cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [lade_pkg::SAMPLE_W-1:0] in_sample,
  output lade_pkg::lade_scale_req_t           scale_req,
  input  logic                                scale_ready
);
  import lade_pkg::*;

  lade_state_t state_r, state_nxt;

  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [DEC_W-1:0]           rem_r, rem_nxt;
  logic [DEC_W-1:0]           den_r, den_nxt;
  logic [GAIN_FRAC-1:0]       quo_r, quo_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [POS_W-1:0]           d_r, d_nxt;
  logic [GAIN_W-1:0]          gain_r, gain_nxt;

  // The one shared arithmetic unit: a - b, with the sign bit as borrow.
  logic [SUB_W-1:0] a_op, b_op, diff;
  logic             borrow;

  assign diff   = a_op - b_op;
  assign borrow = diff[SUB_W-1];

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_ATK;
      ST_ATK:  state_nxt = borrow ? ST_DIV : ST_HOLD;
      ST_HOLD: state_nxt = borrow ? ST_DSUB : ST_MUL;
      ST_DSUB: state_nxt = ST_DCMP;
      ST_DCMP: state_nxt = borrow ? ST_DNUM : ST_MUL;
      ST_DNUM: state_nxt = ST_DIV;
      ST_DIV:  if (step_r == DIV_LAST) state_nxt = ST_MUL;
      ST_MUL:  if (scale_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [DEC_W:0]       rem_dbl;
    logic [GAIN_FRAC-1:0] quo_shift;

    rem_dbl    = {rem_r, 1'b0};
    quo_shift  = '0;
    a_op       = '0;
    b_op       = '0;
    pos_nxt    = pos_r;
    sample_nxt = sample_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    d_nxt      = d_r;
    gain_nxt   = gain_r;
    scale_req  = '{valid: 1'b0, sample: sample_r, gain: gain_r};

    case (state_r)
      ST_IDLE: begin
        sample_nxt = in_sample;
      end
      // Attack when position < attack_len; the numerator is the position.
      ST_ATK: begin
        a_op     = SUB_W'(pos_r);
        b_op     = SUB_W'(cfg.attack_len);
        rem_nxt  = pos_r[DEC_W-1:0];
        den_nxt  = cfg.attack_len;
        quo_nxt  = '0;
        step_nxt = '0;
        gain_nxt = UNITY;
      end
      // Hold while position <= hold_end.
      ST_HOLD: begin
        a_op = SUB_W'(cfg.hold_end);
        b_op = SUB_W'(pos_r);
      end
      ST_DSUB: begin
        a_op  = SUB_W'(pos_r);
        b_op  = SUB_W'(cfg.hold_end);
        d_nxt = diff[POS_W-1:0];
      end
      // Silent once the decay distance reaches decay_len.
      ST_DCMP: begin
        a_op     = SUB_W'(d_r);
        b_op     = SUB_W'(cfg.decay_len);
        gain_nxt = '0;
      end
      ST_DNUM: begin
        a_op     = SUB_W'(cfg.decay_len);
        b_op     = SUB_W'(d_r);
        rem_nxt  = diff[DEC_W-1:0];
        den_nxt  = cfg.decay_len;
        quo_nxt  = '0;
        step_nxt = '0;
      end
      // The numerator is always below the divisor, so only the fraction
      // bits are produced, one per cycle.
      ST_DIV: begin
        a_op      = SUB_W'(rem_dbl);
        b_op      = SUB_W'(den_r);
        quo_shift = {quo_r[GAIN_FRAC-2:0], ~borrow};
        quo_nxt   = quo_shift;
        rem_nxt   = borrow ? rem_dbl[DEC_W-1:0] : diff[DEC_W-1:0];
        step_nxt  = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          gain_nxt = {1'b0, quo_shift};
        end
      end
      ST_MUL: begin
        scale_req.valid = 1'b1;
        if (scale_ready && (pos_r != POS_MAX)) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      default: begin
        sample_nxt = sample_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    step_r   <= step_nxt;
    d_r      <= d_nxt;
    gain_r   <= gain_nxt;
  end

  a_accept_to_atk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_ATK))
    else $error("accepted request did not start the gain sequence");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    scale_req.valid |-> (scale_req.gain <= UNITY))
    else $error("gain above unity");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (scale_req.valid && scale_ready && (pos_r != POS_MAX))
      |=> (pos_r == $past(pos_r) + POS_W'(1)))
    else $error("position did not advance after a result");

endmodule

// ===== hdl/lade_scale.sv =====
// Sample scaling: signed multiply by the gain, floor shift, output register.
// Depends on lade_pkg.
`timescale 1ns / 1ps

module lade_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lade_pkg::lade_scale_req_t     scale_req,
  output logic                          scale_ready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lade_pkg::SAMPLE_W-1:0] out_tdata
);
  import lade_pkg::*;

  logic                     p_valid_r, p_valid_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]      out_data_r, out_data_nxt;
  logic                     adv;

  assign scale_ready = !p_valid_r;
  assign adv         = p_valid_r && (!out_valid_r || out_tready);
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

  always_comb begin
    prod_nxt      = prod_r;
    p_valid_nxt   = p_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (scale_req.valid && !p_valid_r) begin
      prod_nxt    = scale_req.sample * $signed({1'b0, scale_req.gain});
      p_valid_nxt = 1'b1;
    end else if (adv) begin
      p_valid_nxt = 1'b0;
    end
    // An arithmetic shift by the fraction width floors toward minus infinity.
    if (adv) begin
      out_data_nxt  = prod_r[GAIN_FRAC +: SAMPLE_W];
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== verif/linear_attack_decay_envelope_tb.sv =====
// Self-checking testbench for linear_attack_decay_envelope: drives samples and
// register writes, predicts every scaled sample and compares the output stream.
// Depends on lade_pkg and the linear_attack_decay_envelope RTL only.
`timescale 1ns / 1ps

module linear_attack_decay_envelope_tb;
  import lade_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned TARGET_ITEMS = 1175;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 48;

  // Tracks the envelope position and registers and holds the expected
  // scaled samples in request order.
  class envelope_scoreboard;
    logic [ATK_W-1:0]           attack_len;
    logic [HOLD_W-1:0]          hold_end;
    logic [DEC_W-1:0]           decay_len;
    logic [POS_W-1:0]           position;
    logic signed [SAMPLE_W-1:0] expected_samples[$];
    int unsigned                checked;
    int unsigned                mismatches;

    function new();
      attack_len = 1;
      hold_end   = '0;
      decay_len  = 1;
      position   = '0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ATTACK_LEN: attack_len = data[ATK_W-1:0];
        CFG_HOLD_END:   hold_end   = data[HOLD_W-1:0];
        CFG_DECAY_LEN:  decay_len  = data[DEC_W-1:0];
        default: ;
      endcase
    endfunction

    // Gain in unsigned Q1.16 for the current position.
    function logic [GAIN_W-1:0] envelope_gain();
      logic [63:0] pos;
      logic [63:0] past_hold;
      pos = position;
      if (pos < attack_len) return GAIN_W'((pos << GAIN_FRAC) / attack_len);
      if (pos <= hold_end) return UNITY;
      past_hold = pos - hold_end;
      if (past_hold >= decay_len) return '0;
      return GAIN_W'(((decay_len - past_hold) << GAIN_FRAC) / decay_len);
    endfunction

    // Product of sample and gain, rounded toward minus infinity.
    function logic signed [SAMPLE_W-1:0] scaled_sample(logic signed [SAMPLE_W-1:0] s,
                                                       logic [GAIN_W-1:0] g);
      longint value;
      longint gain;
      longint mag;
      value = s;
      gain  = g;
      if (value < 0) begin
        mag   = -value * gain;
        value = -((mag + longint'((1 << GAIN_FRAC) - 1)) >>> GAIN_FRAC);
      end else begin
        value = (value * gain) >>> GAIN_FRAC;
      end
      return value[SAMPLE_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      expected_samples.push_back(scaled_sample(s, envelope_gain()));
      if (position != POS_MAX) position++;
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample_out: result with no request pending, actual %0d", actual);
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (actual !== want) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;   // [23:0] sample_in
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SAMPLE_W-1:0]   out_tdata;  // [23:0] sample_out
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  envelope_scoreboard sb;
  int unsigned        in_idle_pct;
  int unsigned        out_stall_pct;
  int unsigned        sent;
  int unsigned        settings;

  linear_attack_decay_envelope u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata);
  end

  function automatic logic [SAMPLE_W-1:0] corner_sample(int unsigned k);
    case (k)
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return {{(SAMPLE_W-1){1'b0}}, 1'b1};
    endcase
  endfunction

  // Entered at a falling edge; leaves in_tvalid high so back-to-back requests
  // need no second assignment in the same step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(s);
    sent++;
    @(negedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_envelope(input logic [CFG_DATA_W-1:0] a,
                              input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] d);
    program_reg(CFG_ATTACK_LEN, a);
    program_reg(CFG_HOLD_END, h);
    program_reg(CFG_DECAY_LEN, d);
    settings++;
  endtask

  // Stops requests and waits until every expected sample has come out.
  task automatic settle(input int unsigned extra);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected_samples.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("** linear_attack_decay_envelope: FAILED **");
    $finish;
  end

  initial begin
    int unsigned           p;
    int unsigned           n;
    int unsigned           phase;
    logic [CFG_DATA_W-1:0] a;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] d;

    sb            = new();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    sent          = 0;
    settings      = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset registers: zero gain at position 0, silent from then on.
    send_sample(corner_sample(1));
    send_sample(corner_sample(0));

    // Empty attack and a hold that never ends: the sample passes unchanged.
    settle(4);
    set_envelope('0, 25'h0FF_FFFF, '1);
    for (int k = 0; k < 5; k++) send_sample(corner_sample(k));

    // Short sweep through attack, hold, decay and silence.
    settle(4);
    p = sb.position;
    set_envelope(CFG_DATA_W'(p + 4), CFG_DATA_W'(p + 6), 3);
    for (int k = 0; k < 11; k++) send_sample(corner_sample(k % 5));

    // Zero decay length goes silent right after the hold.
    settle(4);
    p = sb.position;
    set_envelope('0, CFG_DATA_W'(p + 2), '0);
    for (int k = 0; k < 4; k++) send_sample(corner_sample(k));

    // Attack wins over a hold end that lies behind the position; the write
    // to the unused index must leave attack_len alone.
    settle(4);
    p = sb.position;
    set_envelope(CFG_DATA_W'(p + 3), 2, 5);
    program_reg(CFG_UNUSED, 1);
    send_sample(corner_sample(1));
    send_sample(corner_sample(0));

    // Bit 24 of the hold_end write is beyond the register and must be dropped.
    settle(4);
    p = sb.position;
    set_envelope('0, (25'd1 << 24) | 25'(p + 1), 2);
    for (int k = 0; k < 3; k++) send_sample(corner_sample(k));

    phase = 0;
    while (sent < TARGET_ITEMS) begin
      settle(4);
      case (phase % 5)
        1:       begin in_idle_pct = 47; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 47; end
        3:       begin in_idle_pct = 36; out_stall_pct = 36; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      p = sb.position;
      n = $urandom_range(16, 48);
      case ($urandom_range(0, 7))
        0: begin a = '1; h = 25'h0FF_FFFF; d = '1; end
        1: begin a = '0; h = '0; d = '1; end
        2: begin a = 1; h = '0; d = '0; end
        3: begin
          a = CFG_DATA_W'($urandom);
          h = CFG_DATA_W'($urandom);
          d = CFG_DATA_W'($urandom);
        end
        default: begin
          a = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(p + $urandom_range(0, n / 2))
                                          : CFG_DATA_W'(p * $urandom_range(2, 64));
          if ($urandom_range(0, 7) == 0) a = '0;
          h = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, p))
                                          : CFG_DATA_W'(a + $urandom_range(0, n / 4));
          h[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
          d = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                          : CFG_DATA_W'($urandom_range(1, n));
        end
      endcase
      set_envelope(a, h, d);
      if ($urandom_range(0, 3) == 0) program_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_sample(corner_sample($urandom_range(0, 4)));
        else send_sample(SAMPLE_W'($urandom));
      end
      phase++;
    end

    settle(DRAIN_CYCLES);
    $display("Run: %0d samples under %0d envelope settings, final position %0d.",
             sent, settings, sb.position);
    $display("Compared %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** linear_attack_decay_envelope: PASSED **");
    end else begin
      $display("** linear_attack_decay_envelope: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lade_pkg.sv
hdl/lade_cfg_regs.sv
hdl/lade_gain_seq.sv
hdl/lade_scale.sv
hdl/linear_attack_decay_envelope.sv
verif/linear_attack_decay_envelope_tb.sv
